FILE: rtl/udsfd_pkg.sv
`default_nettype none

package udsfd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned SIZE_W = 16;

    localparam logic [BYTE_W-1:0] SID_SESSION     = 8'h10;
    localparam logic [BYTE_W-1:0] SUB_PROGRAMMING = 8'h03;
    localparam logic [BYTE_W-1:0] SID_DOWNLOAD    = 8'h34;
    localparam logic [BYTE_W-1:0] SID_TRANSFER    = 8'h36;
    localparam logic [BYTE_W-1:0] SID_EXIT        = 8'h37;
    localparam logic [BYTE_W-1:0] SID_CHECK       = 8'h31;
    localparam logic [BYTE_W-1:0] RESP_OFFSET     = 8'h40;
    localparam logic [BYTE_W-1:0] RESP_NEG        = 8'h7F;

    localparam logic [BYTE_W-1:0] LEN_SESSION  = 8'd2;
    localparam logic [BYTE_W-1:0] LEN_DOWNLOAD = 8'd3;
    localparam logic [BYTE_W-1:0] LEN_SHORT    = 8'd1;

    localparam logic [SIZE_W-1:0] CODE_SIZE_RESET = 16'h3800;

    typedef enum logic [4:0] {
        PH_SESSION  = 5'b00001,
        PH_DOWNLOAD = 5'b00010,
        PH_TRANSFER = 5'b00100,
        PH_EXIT     = 5'b01000,
        PH_CHECK    = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [BYTE_W-1:0] response_byte;
        logic              program_page;
        logic [BYTE_W-1:0] page_number;
        logic              mark_app_valid;
        logic              restart_to_app;
    } t_rsp;

endpackage

`default_nettype wire

FILE: rtl/udsfd_if.sv
`default_nettype none

interface udsfd_req_if
    import udsfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic              func;
    logic [BYTE_W-1:0] sid;
    logic [BYTE_W-1:0] req_len;
    logic [BYTE_W-1:0] first_byte;
    logic [BYTE_W-1:0] second_byte;

    modport source (output valid, func, sid, req_len, first_byte, second_byte, input ready);
    modport sink   (input valid, func, sid, req_len, first_byte, second_byte, output ready);
endinterface

interface udsfd_rsp_if
    import udsfd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] response_byte;
    logic              program_page;
    logic [BYTE_W-1:0] page_number;
    logic              mark_app_valid;
    logic              restart_to_app;

    modport source (output valid, response_byte, program_page, page_number,
                    mark_app_valid, restart_to_app, input ready);
    modport sink   (input valid, response_byte, program_page, page_number,
                    mark_app_valid, restart_to_app, output ready);
endinterface

`default_nettype wire

FILE: rtl/uds_flash_download_sequencer_core.sv
`default_nettype none

// Flash download sequencer: walks a diagnostic download through session, download
// request, transfer data, transfer exit and check. i_req.ready drops only while the
// skid entry is occupied; otherwise one request is taken per clock. The phase and
// counters update at the accepting edge and responses go to a registered o_rsp
// stage backed by one skid entry, so one more request is taken while a response
// waits. Non-functional requests with an unknown sid give no response. The user
// writes the size limit via i_cfg_we/i_cfg_wdata only while idle; nothing enforces it.
module uds_flash_download_sequencer_core
    import udsfd_pkg::*;
#(
    parameter int unsigned PAGE_BYTES = 128
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_cfg_we,
    input  wire  [SIZE_W-1:0] i_cfg_wdata,
    udsfd_req_if.sink         i_req,
    udsfd_rsp_if.source       o_rsp
);

    localparam logic [BYTE_W-1:0] LEN_TRANSFER = BYTE_W'(PAGE_BYTES + 1);
    localparam logic [SIZE_W-1:0] PAGE_INC     = SIZE_W'(PAGE_BYTES);

    logic [SIZE_W-1:0] r_max_size, n_max_size;
    t_phase            r_phase, n_phase;
    logic [SIZE_W-1:0] r_code_size, n_code_size;
    logic [SIZE_W-1:0] r_bytes, n_bytes;
    logic [BYTE_W-1:0] r_page, n_page;

    logic              r_out_vld, n_out_vld;
    t_rsp              r_out, n_out;
    logic              r_skid_vld, n_skid_vld;
    t_rsp              r_skid, n_skid;

    logic              req_fire;
    logic              res_vld;
    logic              known;
    logic              ok;
    t_rsp              res;
    logic [SIZE_W-1:0] req_size;
    logic [SIZE_W-1:0] bytes_sum;
    logic [BYTE_W-1:0] pos;

    assign i_req.ready = !r_skid_vld;
    assign req_fire    = i_req.valid && !r_skid_vld;
    assign req_size    = {i_req.first_byte, i_req.second_byte};
    assign bytes_sum   = r_bytes + PAGE_INC;
    assign pos         = i_req.sid + RESP_OFFSET;

    always_comb begin
        n_max_size  = i_cfg_we ? i_cfg_wdata : r_max_size;
        n_phase     = r_phase;
        n_code_size = r_code_size;
        n_bytes     = r_bytes;
        n_page      = r_page;
        res_vld     = 1'b0;
        known       = 1'b1;
        ok          = 1'b0;
        res         = '0;
        res.response_byte = pos;

        if (req_fire) begin
            if (i_req.func) begin
                n_phase           = PH_DOWNLOAD;
                res_vld           = 1'b1;
                res.response_byte = SID_SESSION + RESP_OFFSET;
            end else begin
                case (i_req.sid)
                    SID_SESSION: begin
                        if (i_req.first_byte == SUB_PROGRAMMING && i_req.req_len == LEN_SESSION
                                && r_phase == PH_SESSION) begin
                            ok      = 1'b1;
                            n_phase = PH_DOWNLOAD;
                        end
                    end
                    SID_DOWNLOAD: begin
                        if (r_phase == PH_DOWNLOAD && i_req.req_len == LEN_DOWNLOAD) begin
                            // size loads even when the request is then refused
                            n_code_size = req_size;
                            if (req_size < r_max_size) begin
                                ok      = 1'b1;
                                n_phase = PH_TRANSFER;
                                n_bytes = '0;
                                n_page  = '0;
                            end
                        end
                    end
                    SID_TRANSFER: begin
                        if (r_phase == PH_TRANSFER && i_req.req_len == LEN_TRANSFER) begin
                            ok               = 1'b1;
                            res.program_page = 1'b1;
                            res.page_number  = r_page;
                            n_page           = r_page + 8'd1;
                            n_bytes          = bytes_sum;
                            if (bytes_sum == r_code_size) begin
                                n_phase = PH_EXIT;
                            end
                        end
                    end
                    SID_EXIT: begin
                        if (r_phase == PH_EXIT && i_req.req_len == LEN_SHORT) begin
                            ok      = 1'b1;
                            n_phase = PH_CHECK;
                        end
                    end
                    SID_CHECK: begin
                        if (r_phase == PH_CHECK && i_req.req_len == LEN_SHORT) begin
                            ok                 = 1'b1;
                            n_phase            = PH_SESSION;
                            res.mark_app_valid = 1'b1;
                            res.restart_to_app = 1'b1;
                        end
                    end
                    default: begin
                        known = 1'b0;
                    end
                endcase
                res_vld = known;
                if (known && !ok) begin
                    // refuse and drop back to the session phase
                    n_phase           = PH_SESSION;
                    res               = '0;
                    res.response_byte = RESP_NEG;
                end
            end
        end
    end

    // output register with one skid entry behind it
    always_comb begin
        n_out_vld  = r_out_vld;
        n_out      = r_out;
        n_skid_vld = r_skid_vld;
        n_skid     = r_skid;
        if (!r_out_vld || o_rsp.ready) begin
            if (r_skid_vld) begin
                n_out_vld  = 1'b1;
                n_out      = r_skid;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld = res_vld;
                n_out     = res;
            end
        end else if (res_vld) begin
            n_skid_vld = 1'b1;
            n_skid     = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size  <= CODE_SIZE_RESET;
            r_phase     <= PH_SESSION;
            r_code_size <= '0;
            r_bytes     <= '0;
            r_page      <= '0;
            r_out_vld   <= 1'b0;
            r_skid_vld  <= 1'b0;
        end else begin
            r_max_size  <= n_max_size;
            r_phase     <= n_phase;
            r_code_size <= n_code_size;
            r_bytes     <= n_bytes;
            r_page      <= n_page;
            r_out_vld   <= n_out_vld;
            r_skid_vld  <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.response_byte  = r_out.response_byte;
    assign o_rsp.program_page   = r_out.program_page;
    assign o_rsp.page_number    = r_out.page_number;
    assign o_rsp.mark_app_valid = r_out.mark_app_valid;
    assign o_rsp.restart_to_app = r_out.restart_to_app;

endmodule

`default_nettype wire

FILE: test/uds_flash_download_sequencer_core_tb.sv
`timescale 1ns / 100ps

module uds_flash_download_sequencer_core_tb;
    import udsfd_pkg::*;

    localparam int unsigned PAGE_BYTES = 128;
    localparam logic [BYTE_W-1:0] LEN_TRANSFER = 8'(PAGE_BYTES + 1);
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned DRAIN_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic cfg_we;
    logic [SIZE_W-1:0] cfg_wdata;

    udsfd_req_if req_if ();
    udsfd_rsp_if rsp_if ();

    uds_flash_download_sequencer_core #(
        .PAGE_BYTES(PAGE_BYTES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow copy of the sequencer state
    t_phase            dl_phase;
    logic [SIZE_W-1:0] size_limit;
    logic [SIZE_W-1:0] code_size;
    logic [SIZE_W-1:0] bytes_received;
    logic [BYTE_W-1:0] next_page;

    t_rsp pending_responses[$];
    int   error_count;
    int   answered_requests;
    int   burst_left;
    bit   sender_gaps;

    // Receiver stall pattern, reloaded each time the 4-bit slot counter wraps
    logic [3:0]  rsp_slot = '0;
    logic [15:0] rsp_bits = '1;

    always @(posedge i_clk) begin
        if (rsp_slot == 4'd0) begin
            case ($urandom_range(0, 3))
                0: rsp_bits = 16'hFFFF;
                1: rsp_bits = 16'($urandom);
                2: rsp_bits = 16'($urandom | $urandom);
                default: rsp_bits = 16'h0F0F;
            endcase
        end
        rsp_if.ready <= rsp_bits[rsp_slot];
        rsp_slot <= rsp_slot + 4'd1;
    end

    function automatic bit predict_download_step(input logic func, input logic [7:0] sid,
                                                 input logic [7:0] len, input logic [7:0] b0,
                                                 input logic [7:0] b1, output t_rsp rsp);
        logic [BYTE_W-1:0] pos_rsp;
        pos_rsp = sid + RESP_OFFSET;
        rsp = '0;
        if (func) begin
            dl_phase = PH_DOWNLOAD;
            rsp.response_byte = SID_SESSION + RESP_OFFSET;
            return 1'b1;
        end
        case (sid)
            SID_SESSION: begin
                if (b0 == SUB_PROGRAMMING && len == LEN_SESSION && dl_phase == PH_SESSION) begin
                    dl_phase = PH_DOWNLOAD;
                    rsp.response_byte = pos_rsp;
                    return 1'b1;
                end
            end
            SID_DOWNLOAD: begin
                if (dl_phase == PH_DOWNLOAD && len == LEN_DOWNLOAD) begin
                    // size is loaded even when the request is then refused
                    code_size = {b0, b1};
                    if (code_size < size_limit) begin
                        dl_phase = PH_TRANSFER;
                        bytes_received = '0;
                        next_page = '0;
                        rsp.response_byte = pos_rsp;
                        return 1'b1;
                    end
                end
            end
            SID_TRANSFER: begin
                if (dl_phase == PH_TRANSFER && len == LEN_TRANSFER) begin
                    rsp.response_byte = pos_rsp;
                    rsp.program_page = 1'b1;
                    rsp.page_number = next_page;
                    next_page = next_page + 8'd1;
                    bytes_received = bytes_received + 16'(PAGE_BYTES);
                    if (bytes_received == code_size) begin
                        dl_phase = PH_EXIT;
                    end
                    return 1'b1;
                end
            end
            SID_EXIT: begin
                if (dl_phase == PH_EXIT && len == LEN_SHORT) begin
                    dl_phase = PH_CHECK;
                    rsp.response_byte = pos_rsp;
                    return 1'b1;
                end
            end
            SID_CHECK: begin
                if (dl_phase == PH_CHECK && len == LEN_SHORT) begin
                    dl_phase = PH_SESSION;
                    rsp.response_byte = pos_rsp;
                    rsp.mark_app_valid = 1'b1;
                    rsp.restart_to_app = 1'b1;
                    return 1'b1;
                end
            end
            default: begin
                return 1'b0;
            end
        endcase
        dl_phase = PH_SESSION;
        rsp.response_byte = RESP_NEG;
        return 1'b1;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_responses.size() == 0) begin
                $error("response 0x%0h with no request outstanding", rsp_if.response_byte);
                error_count++;
            end else begin
                want = pending_responses.pop_front();
                compare_field("response_byte", want.response_byte, rsp_if.response_byte);
                compare_field("program_page", 8'(want.program_page), 8'(rsp_if.program_page));
                compare_field("page_number", want.page_number, rsp_if.page_number);
                compare_field("mark_app_valid", 8'(want.mark_app_valid),
                              8'(rsp_if.mark_app_valid));
                compare_field("restart_to_app", 8'(want.restart_to_app),
                              8'(rsp_if.restart_to_app));
            end
        end
    end

    task automatic send_request(input logic func, input logic [7:0] sid, input logic [7:0] len,
                                input logic [7:0] b0, input logic [7:0] b1);
        t_rsp rsp;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (sender_gaps) begin
                req_if.valid <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
        end
        req_if.valid       <= 1'b1;
        req_if.func        <= func;
        req_if.sid         <= sid;
        req_if.req_len     <= len;
        req_if.first_byte  <= b0;
        req_if.second_byte <= b1;
        do @(posedge i_clk); while (!req_if.ready);
        if (predict_download_step(func, sid, len, b0, b1, rsp)) begin
            pending_responses.push_back(rsp);
            answered_requests++;
        end
        burst_left--;
    endtask

    // Drop valid, collect every outstanding response and let trailing requests settle
    task automatic wait_for_idle();
        int waited;
        waited = 0;
        req_if.valid <= 1'b0;
        while (pending_responses.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_size_limit(input logic [SIZE_W-1:0] value);
        wait_for_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        size_limit = value;
    endtask

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        dl_phase = PH_SESSION;
        size_limit = CODE_SIZE_RESET;
        code_size = '0;
        bytes_received = '0;
        next_page = '0;
        @(posedge i_clk);
    endtask

    task automatic send_noise();
        logic [7:0] sid;
        logic [7:0] len;
        case ($urandom_range(0, 6))
            0: sid = SID_SESSION;
            1: sid = SID_DOWNLOAD;
            2: sid = SID_TRANSFER;
            3: sid = SID_EXIT;
            4: sid = SID_CHECK;
            default: sid = 8'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: len = LEN_SHORT;
            1: len = LEN_SESSION;
            2: len = LEN_DOWNLOAD;
            3: len = LEN_TRANSFER;
            default: len = 8'($urandom);
        endcase
        send_request($urandom_range(0, 15) == 0, sid, len, 8'($urandom), 8'($urandom));
    endtask

    // Occasionally slip a stray request in ahead of the intended one
    task automatic send_in_flow(input logic [7:0] sid, input logic [7:0] len,
                                input logic [7:0] b0, input logic [7:0] b1);
        if ($urandom_range(0, 9) == 0) begin
            send_noise();
        end
        send_request(1'b0, sid, len, b0, b1);
    endtask

    task automatic run_random_flow();
        int pages;
        logic [SIZE_W-1:0] size;
        pages = $urandom_range(1, 6);
        case ($urandom_range(0, 7))
            0: size = 16'($urandom);
            1: size = 16'(pages * PAGE_BYTES + $urandom_range(1, PAGE_BYTES - 1));
            default: size = 16'(pages * PAGE_BYTES);
        endcase
        if ($urandom_range(0, 1)) begin
            send_request(1'b1, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
            send_in_flow(SID_SESSION, LEN_SESSION, SUB_PROGRAMMING, 8'($urandom));
        end
        send_in_flow(SID_DOWNLOAD, LEN_DOWNLOAD, size[15:8], size[7:0]);
        repeat (pages) send_in_flow(SID_TRANSFER, LEN_TRANSFER, 8'($urandom), 8'($urandom));
        send_in_flow(SID_EXIT, LEN_SHORT, 8'($urandom), 8'($urandom));
        send_in_flow(SID_CHECK, LEN_SHORT, 8'($urandom), 8'($urandom));
    endtask

    task automatic test_directed();
        send_request(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'h38, 8'h00);
        send_request(1'b0, SID_SESSION, LEN_SESSION, 8'h02, 8'h00);
        send_request(1'b0, SID_SESSION, LEN_DOWNLOAD, SUB_PROGRAMMING, 8'h00);
        send_request(1'b0, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(1'b0, SID_SESSION, LEN_SESSION, SUB_PROGRAMMING, 8'hFF);
        send_request(1'b0, SID_TRANSFER, LEN_TRANSFER, 8'h00, 8'h00);
        send_request(1'b0, SID_SESSION, LEN_SESSION, SUB_PROGRAMMING, 8'h00);
        send_request(1'b0, SID_DOWNLOAD, LEN_SESSION, 8'h01, 8'h00);
        send_request(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'h01, 8'h00);
        send_request(1'b0, SID_TRANSFER, LEN_TRANSFER, 8'hFF, 8'hFF);
        send_request(1'b0, SID_TRANSFER, LEN_TRANSFER, 8'h00, 8'h00);
        send_request(1'b0, SID_CHECK, LEN_SHORT, 8'h00, 8'h00);
        send_request(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        // one below the limit, and not a whole number of pages
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'h37, 8'hFF);
        send_request(1'b0, SID_TRANSFER, 8'(PAGE_BYTES), 8'h00, 8'h00);
        send_request(1'b0, SID_SESSION, LEN_SESSION, SUB_PROGRAMMING, 8'h00);
        send_request(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'h00, 8'h80);
        send_request(1'b0, SID_TRANSFER, LEN_TRANSFER, 8'h00, 8'h00);
        send_request(1'b0, SID_EXIT, LEN_SHORT, 8'h00, 8'h00);
        send_request(1'b0, SID_CHECK, LEN_SHORT, 8'h00, 8'h00);
        send_request(1'b0, SID_CHECK, LEN_SHORT, 8'h00, 8'h00);
        send_request(1'b0, 8'h35, LEN_SHORT, 8'h00, 8'h00);
    endtask

    task automatic test_size_limit();
        // nothing fits under a zero limit
        write_size_limit(16'h0000);
        send_request(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'h00, 8'h00);
        write_size_limit(16'hFFFF);
        send_request(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'hFF, 8'hFF);
        send_request(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'hFF, 8'hFE);
        repeat (3) send_request(1'b0, SID_TRANSFER, LEN_TRANSFER, 8'h00, 8'h00);
        send_request(1'b0, SID_EXIT, LEN_SHORT, 8'h00, 8'h00);
        write_size_limit(16'h0081);
        send_request(1'b0, SID_SESSION, LEN_SESSION, SUB_PROGRAMMING, 8'h00);
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'h00, 8'h80);
        send_request(1'b0, SID_TRANSFER, LEN_TRANSFER, 8'h00, 8'h00);
        send_request(1'b0, SID_EXIT, LEN_SHORT, 8'h00, 8'h00);
        send_request(1'b0, SID_CHECK, LEN_SHORT, 8'h00, 8'h00);
    endtask

    // Size zero only lands once the byte count wraps after 512 pages
    task automatic test_counter_wrap();
        write_size_limit(16'hFFFF);
        send_request(1'b1, 8'h00, 8'h00, 8'h00, 8'h00);
        send_request(1'b0, SID_DOWNLOAD, LEN_DOWNLOAD, 8'h00, 8'h00);
        repeat (65536 / PAGE_BYTES) begin
            send_request(1'b0, SID_TRANSFER, LEN_TRANSFER, 8'($urandom), 8'($urandom));
        end
        send_request(1'b0, SID_EXIT, LEN_SHORT, 8'h00, 8'h00);
        send_request(1'b0, SID_CHECK, LEN_SHORT, 8'h00, 8'h00);
    endtask

    task automatic test_random_flows();
        logic [SIZE_W-1:0] limits[5];
        int goal;
        limits[0] = 16'($urandom);
        limits[1] = CODE_SIZE_RESET;
        limits[2] = 16'hFFFF;
        limits[3] = 16'h0200;
        limits[4] = 16'h0000;
        foreach (limits[i]) begin
            write_size_limit(limits[i]);
            goal = answered_requests + 180;
            while (answered_requests < goal) begin
                sender_gaps = $urandom_range(0, 3) != 0;
                run_random_flow();
            end
        end
        sender_gaps = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.func = 1'b0;
        req_if.sid = '0;
        req_if.req_len = '0;
        req_if.first_byte = '0;
        req_if.second_byte = '0;
        rsp_if.ready = 1'b0;
        error_count = 0;
        answered_requests = 0;
        burst_left = 0;
        sender_gaps = 1'b1;

        apply_reset();
        test_directed();
        test_size_limit();
        test_counter_wrap();
        test_random_flows();
        wait_for_idle();

        if (pending_responses.size() != 0) begin
            $error("%0d responses never arrived", pending_responses.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/udsfd_pkg.sv
rtl/udsfd_if.sv
rtl/uds_flash_download_sequencer_core.sv
test/uds_flash_download_sequencer_core_tb.sv
